/* src/hafp_pkg.sv */
// shared constants, control type and arctangent table for the heading angle pipeline
package hafp_pkg;

	// default configuration
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int COORD_WIDTH_DEF   = 16;

	// fixed-point formats
	localparam int PRESCALE_BITS = 14;
	localparam int XW_GROW       = PRESCALE_BITS + 4;
	localparam int TABLE_SIZE    = 24;
	localparam int ANGLE_FRAC    = 16;
	localparam int ZW            = 27;
	localparam int OUT_W         = 16;
	localparam int OUT_SHIFT     = 9;

	localparam logic signed [ZW-1:0] HALF_TURN_Z = ZW'(180 <<< ANGLE_FRAC);
	localparam logic signed [ZW-1:0] FULL_TURN_Z = ZW'(360 <<< ANGLE_FRAC);
	localparam logic signed [ZW-1:0] ROUND_HALF  = ZW'(1 <<< (OUT_SHIFT - 1));
	localparam logic [OUT_W-1:0]     FULL_TURN_OUT = OUT_W'(46080);

	// per-transaction control that rides along the pipeline
	typedef struct packed {
		logic valid;
		logic zero;
	} hafp_ctl_t;

	// atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_deg(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0:       v = ZW'(2949120);
			1:       v = ZW'(1740967);
			2:       v = ZW'(919879);
			3:       v = ZW'(466945);
			4:       v = ZW'(234379);
			5:       v = ZW'(117304);
			6:       v = ZW'(58666);
			7:       v = ZW'(29335);
			8:       v = ZW'(14668);
			9:       v = ZW'(7334);
			10:      v = ZW'(3667);
			11:      v = ZW'(1833);
			12:      v = ZW'(917);
			13:      v = ZW'(458);
			14:      v = ZW'(229);
			15:      v = ZW'(115);
			16:      v = ZW'(57);
			17:      v = ZW'(29);
			18:      v = ZW'(14);
			19:      v = ZW'(7);
			20:      v = ZW'(4);
			21:      v = ZW'(2);
			22:      v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* src/hafp_front.sv */
// front end: coordinate differences, then half-plane fold and prescale
module hafp_front #(
	parameter int COORD_WIDTH = hafp_pkg::COORD_WIDTH_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  up_valid,
	output logic                                                  up_stall,
	input  logic signed [COORD_WIDTH-1:0]                         origin_x,
	input  logic signed [COORD_WIDTH-1:0]                         origin_y,
	input  logic signed [COORD_WIDTH-1:0]                         target_x,
	input  logic signed [COORD_WIDTH-1:0]                         target_y,
	input  logic                                                  dn_en,
	output hafp_pkg::hafp_ctl_t                                   ctl_s2,
	output logic signed [COORD_WIDTH+hafp_pkg::XW_GROW-1:0]       x_s2,
	output logic signed [COORD_WIDTH+hafp_pkg::XW_GROW-1:0]       y_s2,
	output logic signed [hafp_pkg::ZW-1:0]                        z_s2
);
	import hafp_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int XW = COORD_WIDTH + XW_GROW;

	logic                 valid_s1;
	logic signed [DW-1:0] dx_s1;
	logic signed [DW-1:0] dy_s1;
	logic                 en_s1;
	logic                 en_s2;
	logic signed [XW-1:0] dx_ext;
	logic signed [XW-1:0] dy_ext;
	logic                 neg;

	// a stage loads when it is empty or its contents move on
	assign en_s2    = !ctl_s2.valid || dn_en;
	assign en_s1    = !valid_s1 || en_s2;
	assign up_stall = !en_s1;

	// stage 1: exact differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dx_s1 <= DW'(target_x) - DW'(origin_x);
			dy_s1 <= DW'(target_y) - DW'(origin_y);
		end
	end

	// fold the left half-plane by 180 degrees
	always_comb begin
		neg    = dx_s1[DW-1];
		dx_ext = XW'(dx_s1);
		dy_ext = XW'(dy_s1);
		if (neg) begin
			dx_ext = -dx_ext;
			dy_ext = -dy_ext;
		end
	end

	// stage 2: prescaled vector and starting angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en_s2) begin
			ctl_s2.valid <= valid_s1;
			ctl_s2.zero  <= (dx_s1 == '0) && (dy_s1 == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			x_s2 <= dx_ext <<< PRESCALE_BITS;
			y_s2 <= dy_ext <<< PRESCALE_BITS;
			z_s2 <= neg ? HALF_TURN_Z : '0;
		end
	end

endmodule

/* src/hafp_cordic_stage.sv */
// one vectoring micro-rotation with its pipeline register
module hafp_cordic_stage #(
	parameter int STAGE = 0,
	parameter int XW    = hafp_pkg::COORD_WIDTH_DEF + hafp_pkg::XW_GROW
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hafp_pkg::hafp_ctl_t            up_ctl,
	input  logic signed [XW-1:0]           up_x,
	input  logic signed [XW-1:0]           up_y,
	input  logic signed [hafp_pkg::ZW-1:0] up_z,
	output logic                           up_en,
	input  logic                           dn_en,
	output hafp_pkg::hafp_ctl_t            ctl_s1,
	output logic signed [XW-1:0]           x_s1,
	output logic signed [XW-1:0]           y_s1,
	output logic signed [hafp_pkg::ZW-1:0] z_s1
);
	import hafp_pkg::*;

	localparam logic signed [ZW-1:0] ANG = atan_deg(STAGE);

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [XW-1:0] x_nx;
	logic signed [XW-1:0] y_nx;
	logic signed [ZW-1:0] z_nx;

	assign up_en = !ctl_s1.valid || dn_en;

	// rotate toward the x axis; angle goes up while y is positive
	always_comb begin
		xs = up_x >>> STAGE;
		ys = up_y >>> STAGE;
		if (up_y > 0) begin
			x_nx = up_x + ys;
			y_nx = up_y - xs;
			z_nx = up_z + ANG;
		end else begin
			x_nx = up_x - ys;
			y_nx = up_y + xs;
			z_nx = up_z - ANG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (up_en) begin
			ctl_s1 <= up_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (up_en) begin
			x_s1 <= x_nx;
			y_s1 <= y_nx;
			z_s1 <= z_nx;
		end
	end

endmodule

/* src/hafp_round.sv */
// back end: wrap into one turn, round to 7 fraction bits, output register
module hafp_round (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hafp_pkg::hafp_ctl_t            up_ctl,
	input  logic signed [hafp_pkg::ZW-1:0] up_z,
	output logic                           up_en,
	output logic                           hdg_valid,
	input  logic                           hdg_stall,
	output logic [hafp_pkg::OUT_W-1:0]     heading_deg
);
	import hafp_pkg::*;

	hafp_ctl_t            ctl_s1;
	logic [OUT_W-1:0]     r_s1;
	logic                 en_s1;
	logic                 en_s2;
	logic signed [ZW-1:0] zsum;

	assign en_s2 = !hdg_valid || !hdg_stall;
	assign en_s1 = !ctl_s1.valid || en_s2;
	assign up_en = en_s1;

	// negative angles get a full turn; rounding offset in the same add
	always_comb begin
		zsum = up_z + ((up_z < 0) ? (FULL_TURN_Z + ROUND_HALF) : ROUND_HALF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en_s1) begin
			ctl_s1 <= up_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			r_s1 <= zsum[OUT_SHIFT +: OUT_W];
		end
	end

	// output register: a full turn wraps to zero, equal points give zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdg_valid <= 1'b0;
		end else if (en_s2) begin
			hdg_valid <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			if (ctl_s1.zero) begin
				heading_deg <= '0;
			end else if (r_s1 >= FULL_TURN_OUT) begin
				heading_deg <= r_s1 - FULL_TURN_OUT;
			end else begin
				heading_deg <= r_s1;
			end
		end
	end

endmodule

/* src/heading_angle_from_points_top.sv */
// top level: pipelined vectoring cordic heading angle between two points
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------------------
//   points    | pt_valid / pt_stall  | origin_x, origin_y, target_x, target_y
//   heading   | hdg_valid / hdg_stall| heading_deg (degrees, 7 fraction bits)
//
// one transaction per cycle unless a result held under hdg_stall backs up the pipe; two front-end
// stages, one stage per micro-rotation, one wrap/round stage and the output register.
// reset clears only the control bits of the stages.
// a stage holds only when it is full and the stage after it holds, so bubbles are
// squeezed out and the pipe keeps taking transactions while a result waits.
module heading_angle_from_points_top #(
	parameter int CORDIC_STAGES = hafp_pkg::CORDIC_STAGES_DEF,
	parameter int COORD_WIDTH   = hafp_pkg::COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pt_valid,
	output logic                           pt_stall,
	input  logic signed [COORD_WIDTH-1:0]  origin_x,
	input  logic signed [COORD_WIDTH-1:0]  origin_y,
	input  logic signed [COORD_WIDTH-1:0]  target_x,
	input  logic signed [COORD_WIDTH-1:0]  target_y,
	output logic                           hdg_valid,
	input  logic                           hdg_stall,
	output logic [hafp_pkg::OUT_W-1:0]     heading_deg
);
	import hafp_pkg::*;

	localparam int XW = COORD_WIDTH + XW_GROW;

	hafp_ctl_t            ctl_c [0:CORDIC_STAGES];
	logic signed [XW-1:0] x_c   [0:CORDIC_STAGES];
	logic signed [XW-1:0] y_c   [0:CORDIC_STAGES];
	logic signed [ZW-1:0] z_c   [0:CORDIC_STAGES];
	logic [CORDIC_STAGES:0] en_c;

	// differences and half-plane fold
	hafp_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pt_valid),
		.up_stall (pt_stall),
		.origin_x (origin_x),
		.origin_y (origin_y),
		.target_x (target_x),
		.target_y (target_y),
		.dn_en    (en_c[0]),
		.ctl_s2   (ctl_c[0]),
		.x_s2     (x_c[0]),
		.y_s2     (y_c[0]),
		.z_s2     (z_c[0])
	);

	// micro-rotation chain
	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
		hafp_cordic_stage #(
			.STAGE(k),
			.XW   (XW)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.up_ctl (ctl_c[k]),
			.up_x   (x_c[k]),
			.up_y   (y_c[k]),
			.up_z   (z_c[k]),
			.up_en  (en_c[k]),
			.dn_en  (en_c[k+1]),
			.ctl_s1 (ctl_c[k+1]),
			.x_s1   (x_c[k+1]),
			.y_s1   (y_c[k+1]),
			.z_s1   (z_c[k+1])
		);
	end

	// the last residual vector is not needed past the rotations
	logic unused_xy;
	assign unused_xy = ^{x_c[CORDIC_STAGES], y_c[CORDIC_STAGES]};

	// wrap, round and output register
	hafp_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_ctl      (ctl_c[CORDIC_STAGES]),
		.up_z        (z_c[CORDIC_STAGES]),
		.up_en       (en_c[CORDIC_STAGES]),
		.hdg_valid   (hdg_valid),
		.hdg_stall   (hdg_stall),
		.heading_deg (heading_deg)
	);

endmodule

/* src/hafp_checker.sv */
// port-level checker for the heading angle pipeline, bound to the top level
module hafp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pt_valid,
	input logic                       pt_stall,
	input logic                       hdg_valid,
	input logic                       hdg_stall,
	input logic [hafp_pkg::OUT_W-1:0] heading_deg
);
	import hafp_pkg::*;

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hdg_valid && hdg_stall |=> hdg_valid && $stable(heading_deg))
		else $error("held heading changed");

	// the angle stays below one full turn
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdg_valid |-> heading_deg < FULL_TURN_OUT)
		else $error("heading at or above a full turn");

	// the input only stalls when a finished result is held at the output
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && (!hdg_valid || !hdg_stall) |-> !pt_stall)
		else $error("input stalled with a free output");

endmodule

bind heading_angle_from_points_top hafp_checker u_hafp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pt_valid    (pt_valid),
	.pt_stall    (pt_stall),
	.hdg_valid   (hdg_valid),
	.hdg_stall   (hdg_stall),
	.heading_deg (heading_deg)
);
